// ===== hdl/ifgf_pkg.sv =====
// Shared types and constants for the invalid-frame gap filler.
`default_nettype none

package ifgf_pkg;

  // Field and register widths
  localparam int unsigned SIZE_W   = 14;
  localparam int unsigned OVH_W    = 6;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned GAP_IN_W = 24;
  localparam int unsigned CARRY_W  = 32;
  localparam int unsigned GAP_W    = CARRY_W + 1;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD     = 2'd2;

  // Register reset values
  localparam logic [SIZE_W-1:0] INVALID_SIZE_RST = 14'd1500;
  localparam logic [SIZE_W-1:0] MIN_SIZE_RST     = 14'd60;
  localparam logic [OVH_W-1:0]  OVERHEAD_RST     = 6'd24;

  // Fixed constants of the sizing rule and the byte total
  localparam int unsigned HALVING_MARGIN = 100;
  localparam int unsigned BYTE_TOTAL_ADJ = 20;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // take the transaction, form gap = input + carry
    logic emit_filler;  // send a filler, shrink the gap, bump totals
    logic emit_packet;  // send the real packet, store the carry
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic gap_ge_thr;   // gap still large enough for another filler
    logic slot_free;    // output register can take a new result
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/invalid_frame_gap_filler_core.sv =====
// Top level of the invalid-frame gap filler: controller plus datapath.
//
// Input channel (in_valid / in_stall): one transaction per packet slot with
// its wanted gap in wire bytes. Output channel (out_valid / out_stall): one
// transaction per frame, fillers first, then the real packet with out_last.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 the
// largest filler size, 1 the smallest filler length, 2 the per-frame overhead;
// write only while the block is idle. cfg_ready is always high.
// Timing: a deleted slot is taken and gives no result. A real packet may have
// k fillers (k up to MAX_FILLERS); its first result is registered after the
// input transaction has passed the test state and then the fill or packet
// state. The filler loop tests gap and count in the test state, then sizes
// the filler, sends it and updates gap and totals in the fill state.
// in_stall is high while a transaction is being worked on. A stalled output
// holds its result; the loop waits for the output register to free up.
// Reset (rst_n, synchronous, active low) clears the carried gap and both
// totals and restores the configuration reset values.
`default_nettype none

module invalid_frame_gap_filler_core #(
  parameter int unsigned MAX_FILLERS = 63
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_packet_present,
  input  wire logic [ifgf_pkg::HANDLE_W-1:0]  in_packet_handle,
  input  wire logic [ifgf_pkg::GAP_IN_W-1:0]  in_gap_bytes,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_is_filler,
  output logic [ifgf_pkg::SIZE_W-1:0]         out_filler_length,
  output logic [ifgf_pkg::HANDLE_W-1:0]       out_handle,
  output logic                                out_last,
  output logic [ifgf_pkg::TOTAL_W-1:0]        out_fillers_total,
  output logic [ifgf_pkg::TOTAL_W-1:0]        out_filler_bytes_total,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ifgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ifgf_pkg::SIZE_W-1:0]    cfg_data
);
  import ifgf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  ifgf_ctrl #(
    .MAX_FILLERS (MAX_FILLERS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_packet_present (in_packet_present),
    .in_stall          (in_stall),
    .sts               (sts),
    .cmd               (cmd)
  );

  ifgf_datapath u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_wr                 (cfg_valid && cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_packet_handle       (in_packet_handle),
    .in_gap_bytes           (in_gap_bytes),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_is_filler          (out_is_filler),
    .out_filler_length      (out_filler_length),
    .out_handle             (out_handle),
    .out_last               (out_last),
    .out_fillers_total      (out_fillers_total),
    .out_filler_bytes_total (out_filler_bytes_total)
  );

endmodule

`default_nettype wire

// ===== hdl/ifgf_datapath.sv =====
// Datapath: configuration, gap register, filler sizing, totals and output register.
`default_nettype none

module ifgf_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ifgf_pkg::dp_cmd_t             cmd,
  output ifgf_pkg::dp_sts_t                  sts,
  input  wire logic                          cfg_wr,
  input  wire logic [ifgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ifgf_pkg::SIZE_W-1:0]   cfg_data,
  input  wire logic [ifgf_pkg::HANDLE_W-1:0] in_packet_handle,
  input  wire logic [ifgf_pkg::GAP_IN_W-1:0] in_gap_bytes,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_is_filler,
  output logic [ifgf_pkg::SIZE_W-1:0]        out_filler_length,
  output logic [ifgf_pkg::HANDLE_W-1:0]      out_handle,
  output logic                               out_last,
  output logic [ifgf_pkg::TOTAL_W-1:0]       out_fillers_total,
  output logic [ifgf_pkg::TOTAL_W-1:0]       out_filler_bytes_total
);
  import ifgf_pkg::*;

  logic [SIZE_W-1:0]   inv_size_r;
  logic [SIZE_W-1:0]   min_size_r;
  logic [OVH_W-1:0]    ovh_r;
  logic [CARRY_W-1:0]  carry_r;
  logic [GAP_W-1:0]    gap_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [TOTAL_W-1:0]  fill_cnt_r;
  logic [TOTAL_W-1:0]  byte_cnt_r;

  logic                out_valid_r;
  logic                out_is_filler_r;
  logic [SIZE_W-1:0]   out_len_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic                out_last_r;
  logic [TOTAL_W-1:0]  out_fill_r;
  logic [TOTAL_W-1:0]  out_bytes_r;

  logic [SIZE_W:0]     thr;
  logic                le_inv;
  logic                above_half;
  logic [SIZE_W-1:0]   wire_sz;
  logic                ge_ovh;
  logic [SIZE_W-1:0]   drop;
  logic [SIZE_W-1:0]   len;
  logic [GAP_W-1:0]    gap_nxt;
  logic [TOTAL_W-1:0]  fill_nxt;
  logic [TOTAL_W-1:0]  byte_nxt;
  logic [CARRY_W-1:0]  carry_nxt;

  // Filler sizing from the current gap
  assign thr        = {1'b0, min_size_r} + {{(SIZE_W+1-OVH_W){1'b0}}, ovh_r};
  assign le_inv     = gap_r <= {{(GAP_W-SIZE_W){1'b0}}, inv_size_r};
  assign above_half = ({1'b0, gap_r} + (GAP_W+1)'(HALVING_MARGIN))
                      > {{(GAP_W-SIZE_W){1'b0}}, inv_size_r, 1'b0};

  always_comb begin
    if (le_inv) begin
      wire_sz = gap_r[SIZE_W-1:0];
    end else if (above_half) begin
      wire_sz = inv_size_r;
    end else begin
      wire_sz = gap_r[SIZE_W:1];
    end
  end

  // Frame below overhead still costs the overhead on the wire
  assign ge_ovh = wire_sz >= {{(SIZE_W-OVH_W){1'b0}}, ovh_r};
  assign drop   = ge_ovh ? wire_sz : {{(SIZE_W-OVH_W){1'b0}}, ovh_r};
  assign len    = ge_ovh ? (wire_sz - {{(SIZE_W-OVH_W){1'b0}}, ovh_r}) : '0;

  // Gap, totals and carry updates
  assign gap_nxt  = (gap_r >= {{(GAP_W-SIZE_W){1'b0}}, drop})
                    ? gap_r - {{(GAP_W-SIZE_W){1'b0}}, drop} : '0;
  assign fill_nxt = fill_cnt_r + TOTAL_W'(1);
  assign byte_nxt = byte_cnt_r + {{(TOTAL_W-SIZE_W){1'b0}}, drop}
                    - TOTAL_W'(BYTE_TOTAL_ADJ);
  assign carry_nxt = gap_r[GAP_W-1] ? '1 : gap_r[CARRY_W-1:0];

  assign sts.gap_ge_thr = gap_r >= {{(GAP_W-SIZE_W-1){1'b0}}, thr};
  assign sts.slot_free  = !out_valid_r || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_size_r <= INVALID_SIZE_RST;
      min_size_r <= MIN_SIZE_RST;
      ovh_r      <= OVERHEAD_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_INVALID_SIZE: inv_size_r <= cfg_data;
        CFG_MIN_SIZE:     min_size_r <= cfg_data;
        CFG_OVERHEAD:     ovh_r      <= cfg_data[OVH_W-1:0];
        default: ;
      endcase
    end
  end

  // Running state: carry and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r    <= '0;
      fill_cnt_r <= '0;
      byte_cnt_r <= '0;
    end else begin
      if (cmd.emit_filler) begin
        fill_cnt_r <= fill_nxt;
        byte_cnt_r <= byte_nxt;
      end
      if (cmd.emit_packet) begin
        carry_r <= carry_nxt;
      end
    end
  end

  // Working gap and handle of the transaction in flight
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gap_r    <= {{(GAP_W-GAP_IN_W){1'b0}}, in_gap_bytes} + {1'b0, carry_r};
      handle_r <= in_packet_handle;
    end else if (cmd.emit_filler) begin
      gap_r <= gap_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_filler || cmd.emit_packet) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_filler) begin
      out_is_filler_r <= 1'b1;
      out_len_r       <= len;
      out_handle_r    <= '0;
      out_last_r      <= 1'b0;
      out_fill_r      <= fill_nxt;
      out_bytes_r     <= byte_nxt;
    end else if (cmd.emit_packet) begin
      out_is_filler_r <= 1'b0;
      out_len_r       <= '0;
      out_handle_r    <= handle_r;
      out_last_r      <= 1'b1;
      out_fill_r      <= fill_cnt_r;
      out_bytes_r     <= byte_cnt_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_is_filler          = out_is_filler_r;
  assign out_filler_length      = out_len_r;
  assign out_handle             = out_handle_r;
  assign out_last               = out_last_r;
  assign out_fillers_total      = out_fill_r;
  assign out_filler_bytes_total = out_bytes_r;

endmodule

`default_nettype wire

// ===== hdl/ifgf_ctrl.sv =====
// Controller: sequences fillers and the real packet for each transaction.
`default_nettype none

module ifgf_ctrl #(
  parameter int unsigned MAX_FILLERS = 63
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_packet_present,
  output logic                   in_stall,
  input  wire ifgf_pkg::dp_sts_t sts,
  output ifgf_pkg::dp_cmd_t      cmd
);
  import ifgf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FILLERS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_FILL,
    ST_PKT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state and datapath commands
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    cmd.load        = 1'b0;
    cmd.emit_filler = 1'b0;
    cmd.emit_packet = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // deleted slots are taken and dropped here
        if (accept && in_packet_present) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.gap_ge_thr && (cnt_r < CNT_W'(MAX_FILLERS))) begin
          state_nxt = ST_FILL;
        end else begin
          state_nxt = ST_PKT;
        end
      end
      ST_FILL: begin
        if (sts.slot_free) begin
          cmd.emit_filler = 1'b1;
          cnt_nxt         = cnt_r + CNT_W'(1);
          state_nxt       = ST_TEST;
        end
      end
      ST_PKT: begin
        if (sts.slot_free) begin
          cmd.emit_packet = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and filler count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
